// ----- src/mcusum_pkg.sv -----
// ----------------------------------------------------------------------------
// mcusum_pkg
// Shared widths, register indexes, reset values and sequencer states of the
// multivariate CUSUM chart update block.
// ----------------------------------------------------------------------------
package mcusum_pkg;

  localparam int unsigned DIM_DEF    = 8;
  localparam int unsigned OBS_W      = 16;  // observation / CUSUM component, Q8.8
  localparam int unsigned SUM_W      = 17;  // observation plus CUSUM, Q9.8
  localparam int unsigned ACC_W      = 40;  // squared norm, Q24.16
  localparam int unsigned ROOT_W     = 20;  // distance D, Q12.8
  localparam int unsigned QUO_W      = 17;  // rescaled magnitude before saturation
  localparam int unsigned REM_W      = 21;  // partial remainder of root and divide
  localparam int unsigned CS_W       = 23;  // shared compare-subtract width
  localparam int unsigned MUL_W      = 20;  // shared multiplier operand width
  localparam int unsigned ITER_W     = 5;   // iteration counter
  localparam int unsigned STAT_W     = 32;
  localparam int unsigned K_W        = 16;
  localparam int unsigned H_W        = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic signed [OBS_W-1:0] obs_t;
  typedef logic [STAT_W-1:0]       stat_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  localparam logic [K_W-1:0] K_RESET = 16'd26;
  localparam logic [H_W-1:0] H_RESET = 32'd655360;

  localparam cfg_idx_t REG_ALLOWANCE_K     = 1'd0;
  localparam cfg_idx_t REG_CONTROL_LIMIT_H = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQR,
    ST_ACC,
    ST_ROOT,
    ST_DIFF,
    ST_STAT,
    ST_SAT,
    ST_RDSUM,
    ST_MAG,
    ST_DIV,
    ST_WB,
    ST_DONE
  } mcu_state_t;

endpackage

// ----- src/mcusum_in_if.sv -----
// ----------------------------------------------------------------------------
// mcusum_in_if
// Observation component channel: one vector component per transfer.
// ----------------------------------------------------------------------------
interface mcusum_in_if;
  import mcusum_pkg::*;

  logic valid;
  logic ready;
  obs_t obs_component;
  logic is_last;

  modport source (output valid, output obs_component, output is_last, input ready);
  modport sink   (input valid, input obs_component, input is_last, output ready);
endinterface

// ----- src/mcusum_out_if.sv -----
// ----------------------------------------------------------------------------
// mcusum_out_if
// Chart result channel: one transfer per finished vector.
// ----------------------------------------------------------------------------
interface mcusum_out_if;
  import mcusum_pkg::*;

  logic   valid;
  logic   ready;
  stat_t  chart_stat;
  logic   alarm;
  count_t sample_count;

  modport source (output valid, output chart_stat, output alarm, output sample_count,
                  input ready);
  modport sink   (input valid, input chart_stat, input alarm, input sample_count,
                  output ready);
endinterface

// ----- src/mcusum_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mcusum_cfg_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface mcusum_cfg_if;
  import mcusum_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  reg_index;
  cfg_data_t wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- src/mcusum_chart_update.sv -----
// Mid-vector component: after each transfer, input ready stays low through ST_SUM, ST_SQR and ST_ACC.
// Vector end: the result waits on the 20-step square root and, when D > k, on
// the 17-step divide per received component, both on one shared
// compare-subtract unit.
// Reset (rst_n low, synchronous) clears the CUSUM valid bits, counters,
// registers to their reset values, and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// mcusum_chart_update
// Crosier multivariate CUSUM update, identity covariance, zero mean. Sums each
// component with the kept CUSUM, accumulates the squared norm, then at vector
// end takes D = isqrt; if D > k it rescales the CUSUM vector by (D-k)/D and
// reports (D-k)^2 against the control limit, else clears the CUSUM and reports zero.
// ----------------------------------------------------------------------------
module mcusum_chart_update #(
  parameter int unsigned DIM = mcusum_pkg::DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  mcusum_in_if.sink           in_if,
  mcusum_out_if.source        out_if,
  mcusum_cfg_if.sink          cfg_if
);
  import mcusum_pkg::*;

  localparam int unsigned IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

  // sequencer
  mcu_state_t state_r, state_nxt;

  // configuration
  logic [K_W-1:0] k_r;
  logic [H_W-1:0] h_r;

  // vector storage
  obs_t                    cus_mem [DIM];
  logic signed [SUM_W-1:0] sum_mem [DIM];
  logic [DIM-1:0]          cus_vld_r;
  obs_t                    cus_rd_r;
  logic signed [SUM_W-1:0] sum_rd_r;

  // datapath registers
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  i_r;
  obs_t              obs_r;
  logic              last_r;
  logic [SUM_W-1:0]  mag_r;
  logic [ACC_W-1:0]  prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  sh_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W-1:0] diff_r;
  logic              neg_r;
  logic [ITER_W-1:0] cnt_r;
  stat_t             stat_r;
  count_t            vcount_r;

  // output stage
  logic   out_valid_r;
  stat_t  out_stat_r;
  logic   out_alarm_r;
  count_t out_count_r;

  // combinational
  logic                    in_xfer;
  logic                    out_free;
  logic                    vec_end;
  logic                    d_above_k;
  obs_t                    cus_eff;
  logic signed [SUM_W-1:0] sum_s;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        rd_mag;
  logic [ACC_W-1:0]        acc_sum;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [2*MUL_W-1:0]      mul_p;
  logic [CS_W-1:0]         cs_a, cs_b, cs_dif;
  logic                    cs_ge;
  logic [QUO_W-1:0]        quo;
  logic [QUO_W-1:0]        quo_neg;
  obs_t                    wb_val;
  count_t                  vcount_nxt;

  assign in_xfer   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_r || out_if.ready;
  assign vec_end   = last_r || (idx_r == LAST_IDX);
  assign d_above_k = root_r > {{(ROOT_W-K_W){1'b0}}, k_r};

  // sum of observation and kept CUSUM, and its magnitude
  assign cus_eff = cus_vld_r[idx_r] ? cus_rd_r : '0;
  assign sum_s   = {obs_r[OBS_W-1], obs_r} + {cus_eff[OBS_W-1], cus_eff};
  assign sum_mag = sum_s[SUM_W-1] ? (~sum_s + 1'b1) : sum_s;
  assign rd_mag  = sum_rd_r[SUM_W-1] ? (~sum_rd_r + 1'b1) : sum_rd_r;
  assign acc_sum = acc_r + prod_r;

  // shared multiplier and compare-subtract unit
  assign mul_p  = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  assign cs_ge  = cs_a >= cs_b;
  assign cs_dif = cs_a - cs_b;

  // saturate the rescaled magnitude back to a signed Q8.8 component
  assign quo     = sh_r[QUO_W-1:0];
  assign quo_neg = '0 - quo;
  always_comb begin
    if (neg_r) begin
      wb_val = (quo > QUO_W'(32768)) ? obs_t'(16'sh8000) : quo_neg[OBS_W-1:0];
    end else begin
      wb_val = (quo > QUO_W'(32767)) ? obs_t'(16'sh7FFF) : quo[OBS_W-1:0];
    end
  end

  assign vcount_nxt = (vcount_r == '1) ? vcount_r : vcount_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SQR;
      ST_SQR:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = vec_end ? ST_ROOT : ST_IDLE;
      ST_ROOT:  if (cnt_r == ITER_W'(ROOT_W - 1)) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = d_above_k ? ST_STAT : ST_DONE;
      ST_STAT:  state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_RDSUM;
      ST_RDSUM: begin
        if (i_r > idx_r) begin
          state_nxt = (i_r == LAST_IDX) ? ST_DONE : ST_RDSUM;
        end else begin
          state_nxt = ST_MAG;
        end
      end
      ST_MAG:   state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == ITER_W'(QUO_W - 1)) state_nxt = ST_WB;
      ST_WB:    state_nxt = (i_r == LAST_IDX) ? ST_DONE : ST_RDSUM;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    in_if.ready = (state_r == ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    cs_a  = '0;
    cs_b  = '0;
    unique case (state_r)
      ST_SQR: begin
        mul_a = MUL_W'(mag_r);
        mul_b = MUL_W'(mag_r);
      end
      ST_STAT: begin
        mul_a = diff_r;
        mul_b = diff_r;
      end
      ST_MAG: begin
        mul_a = MUL_W'(rd_mag);
        mul_b = diff_r;
      end
      ST_ROOT: begin
        cs_a = {rem_r, sh_r[ACC_W-1 -: 2]};
        cs_b = {1'b0, root_r, 2'b01};
      end
      ST_DIV: begin
        cs_a = {2'b00, rem_r[ROOT_W-1:0], sh_r[QUO_W-1]};
        cs_b = {{(CS_W-ROOT_W){1'b0}}, root_r};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign cfg_if.ready        = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.chart_stat   = out_stat_r;
  assign out_if.alarm        = out_alarm_r;
  assign out_if.sample_count = out_count_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
      h_r <= H_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.reg_index)
        REG_ALLOWANCE_K:     k_r <= cfg_if.wdata[K_W-1:0];
        REG_CONTROL_LIMIT_H: h_r <= cfg_if.wdata[H_W-1:0];
        default:             k_r <= k_r;
      endcase
    end
  end

  // CUSUM vector memory, registered read at the current component
  always_ff @(posedge clk) begin
    if (state_r == ST_WB) begin
      cus_mem[i_r] <= wb_val;
    end
    cus_rd_r <= cus_mem[idx_r];
  end

  // sum vector memory, registered read at the rescale index
  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      sum_mem[idx_r] <= sum_s;
    end
    sum_rd_r <= sum_mem[i_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cus_vld_r   <= '0;
      idx_r       <= '0;
      i_r         <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a new result, or drop the one just transferred
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r) inside
        ST_ACC: begin
          cnt_r <= '0;
          if (vec_end) begin
            acc_r <= '0;
          end else begin
            acc_r <= acc_sum;
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_ROOT, ST_DIV: cnt_r <= cnt_r + 1'b1;
        ST_DIFF: begin
          i_r <= '0;
          if (!d_above_k) begin
            cus_vld_r <= '0;
          end
        end
        ST_RDSUM: begin
          if (i_r > idx_r) begin
            cus_vld_r[i_r] <= 1'b0;
            if (i_r != LAST_IDX) i_r <= i_r + 1'b1;
          end
        end
        ST_MAG: cnt_r <= '0;
        ST_WB: begin
          cus_vld_r[i_r] <= 1'b1;
          if (i_r != LAST_IDX) i_r <= i_r + 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            vcount_r <= vcount_nxt;
            idx_r    <= '0;
          end
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    case (state_r) inside
      ST_IDLE: begin
        if (in_xfer) begin
          obs_r  <= in_if.obs_component;
          last_r <= in_if.is_last;
        end
      end
      ST_SUM: mag_r <= sum_mag;
      ST_SQR, ST_STAT: prod_r <= mul_p;
      ST_ACC: begin
        sh_r   <= acc_sum;
        rem_r  <= '0;
        root_r <= '0;
      end
      // one root digit per cycle
      ST_ROOT: begin
        sh_r <= {sh_r[ACC_W-3:0], 2'b00};
        if (cs_ge) begin
          rem_r  <= cs_dif[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= cs_a[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      ST_DIFF: begin
        diff_r <= root_r - {{(ROOT_W-K_W){1'b0}}, k_r};
        if (!d_above_k) stat_r <= '0;
      end
      ST_SAT: stat_r <= (prod_r[ACC_W-1:STAT_W] != '0) ? '1 : prod_r[STAT_W-1:0];
      // product |sum| * (D-k): top bits seed the remainder, low bits shift in
      ST_MAG: begin
        neg_r <= sum_rd_r[SUM_W-1];
        rem_r <= {1'b0, mul_p[QUO_W+ROOT_W-1:QUO_W]};
        sh_r  <= {{(ACC_W-QUO_W){1'b0}}, mul_p[QUO_W-1:0]};
      end
      // one quotient bit per cycle
      ST_DIV: begin
        sh_r[QUO_W-1:0] <= {sh_r[QUO_W-2:0], cs_ge};
        if (cs_ge) begin
          rem_r <= {1'b0, cs_dif[ROOT_W-1:0]};
        end else begin
          rem_r <= {1'b0, cs_a[ROOT_W-1:0]};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_stat_r  <= stat_r;
          out_alarm_r <= stat_r > h_r;
          out_count_r <= vcount_nxt;
        end
      end
      default: neg_r <= neg_r;
    endcase
  end

endmodule

// ----- src/mcusum_chk.sv -----
// ----------------------------------------------------------------------------
// mcusum_chk
// Port-level checks of the chart update block: result hold, busy after an
// input transfer, sample count sequence and alarm consistency.
// ----------------------------------------------------------------------------
module mcusum_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input mcusum_pkg::stat_t    chart_stat,
  input logic                 alarm,
  input mcusum_pkg::count_t   sample_count
);
  import mcusum_pkg::*;

  count_t last_cnt_r;
  logic   seen_r;

  // track the count of the last result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
      seen_r     <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_cnt_r <= sample_count;
      seen_r     <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(chart_stat) && $stable(alarm)
      && $stable(sample_count))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_r |-> sample_count == 32'd1)
    else $error("first result count is not one");

  a_next_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> ((last_cnt_r != '1) && (sample_count == last_cnt_r + 32'd1))
      || ((last_cnt_r == '1) && (sample_count == '1)))
    else $error("sample count out of sequence");

  a_alarm_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && alarm |-> chart_stat != '0)
    else $error("alarm with zero chart statistic");

endmodule

bind mcusum_chart_update mcusum_chk u_mcusum_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .chart_stat   (out_if.chart_stat),
  .alarm        (out_if.alarm),
  .sample_count (out_if.sample_count)
);

// ----- tb/sv/mcusum_chart_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcusum_chart_checker
// Watches the component, result and register channels of the CUSUM chart
// update block. It keeps its own copy of the chart state, predicts the result
// of every finished vector and compares each result transfer against it.
// ----------------------------------------------------------------------------
module mcusum_chart_checker #(
  parameter int unsigned DIM = mcusum_pkg::DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mcusum_in_if        in_ch,
  mcusum_out_if       out_ch,
  mcusum_cfg_if       cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned result_count,
  output int unsigned alarm_count
);
  import mcusum_pkg::*;

  typedef struct {
    stat_t  chart_stat;
    logic   alarm;
    count_t sample_count;
  } chart_result_t;

  // Shadow of the chart state and registers
  obs_t                    cusum[DIM];
  logic signed [SUM_W-1:0] sums[DIM];
  logic [ACC_W-1:0]        norm_sq;
  int unsigned             comp_pos;
  count_t                  vectors_done;
  logic [K_W-1:0]          allowance;
  logic [H_W-1:0]          limit;

  chart_result_t pending_charts[$];

  int unsigned fails     = 0;
  int unsigned waiting   = 0;
  int unsigned seen      = 0;
  int unsigned alarms    = 0;

  assign fail_count   = fails;
  assign pending      = waiting;
  assign result_count = seen;
  assign alarm_count  = alarms;

  // Floor of the square root, one result bit at a time
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Fold one component into the norm; at the vector end rescale and queue a result
  task automatic update_chart(input obs_t obs, input logic last);
    int unsigned     idx;
    int unsigned     used;
    longint          s;
    longint          sv;
    longint          v;
    longint unsigned mag;
    longint unsigned d;
    longint unsigned diff;
    longint unsigned q;
    longint unsigned stat;
    chart_result_t   res;
    idx = (comp_pos >= DIM) ? DIM - 1 : comp_pos;
    s = longint'(obs) + longint'(cusum[idx]);
    sums[idx] = SUM_W'(s);
    mag = (s < 0) ? -s : s;
    norm_sq = ACC_W'(norm_sq + mag * mag);
    if (!last && idx + 1 < DIM) begin
      comp_pos = idx + 1;
      return;
    end

    used = idx + 1;
    d = floor_root(norm_sq);
    stat = 0;
    if (d > allowance) begin
      diff = d - allowance;
      for (int i = 0; i < DIM; i++) begin
        v = 0;
        if (i < used) begin
          sv = longint'(sums[i]);
          q = ((sv < 0) ? -sv : sv) * diff / d;
          if (sv < 0) v = (q > 32768) ? -32768 : -longint'(q);
          else        v = (q > 32767) ? 32767 : longint'(q);
        end
        cusum[i] = obs_t'(v);
      end
      stat = diff * diff;
      if (stat > 64'hFFFF_FFFF) stat = 64'hFFFF_FFFF;
    end else begin
      for (int i = 0; i < DIM; i++) cusum[i] = '0;
    end

    if (vectors_done != '1) vectors_done = vectors_done + 1;
    norm_sq  = '0;
    comp_pos = 0;

    res.chart_stat   = stat_t'(stat);
    res.alarm        = (stat > limit);
    res.sample_count = vectors_done;
    pending_charts.push_back(res);
  endtask

  // Compare a result transfer with the oldest prediction
  task automatic check_result();
    chart_result_t exp_res;
    seen++;
    if (out_ch.alarm) alarms++;
    if (pending_charts.size() == 0) begin
      $error("result transfer with no prediction waiting: chart_stat %0d", out_ch.chart_stat);
      fails++;
      return;
    end
    exp_res = pending_charts.pop_front();
    if (out_ch.chart_stat !== exp_res.chart_stat) begin
      $error("chart_stat mismatch: expected %0d, actual %0d",
             exp_res.chart_stat, out_ch.chart_stat);
      fails++;
    end
    if (out_ch.alarm !== exp_res.alarm) begin
      $error("alarm mismatch: expected %0d, actual %0d", exp_res.alarm, out_ch.alarm);
      fails++;
    end
    if (out_ch.sample_count !== exp_res.sample_count) begin
      $error("sample_count mismatch: expected %0d, actual %0d",
             exp_res.sample_count, out_ch.sample_count);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIM; i++) begin
        cusum[i] = '0;
        sums[i]  = '0;
      end
      norm_sq      = '0;
      comp_pos     = 0;
      vectors_done = '0;
      allowance    = K_RESET;
      limit        = H_RESET;
      pending_charts.delete();
    end else begin
      // Results first: none can come from a component taken at this same edge
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_ALLOWANCE_K:     allowance = cfg_ch.wdata[K_W-1:0];
          REG_CONTROL_LIMIT_H: limit     = cfg_ch.wdata[H_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) update_chart(in_ch.obs_component, in_ch.is_last);
    end
    waiting = pending_charts.size();
  end

endmodule

// ----- tb/sv/mcusum_chart_update_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcusum_chart_update_tb
// Drives observation components and register writes into the CUSUM chart
// update block with bursty input and a stalling result side, and gives the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module mcusum_chart_update_tb;
  import mcusum_pkg::*;

  localparam int unsigned DIM             = DIM_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned DRAIN_CYCLES    = 220;  // longest vector end plus margin
  localparam int unsigned TAIL_CYCLES     = 250;
  localparam int unsigned IDLE_LIMIT      = 3000;

  typedef enum int {
    STYLE_SMALL,
    STYLE_MEDIUM,
    STYLE_FULL,
    STYLE_EXTREME
  } value_style_t;

  logic clk = 1'b0;
  logic rst_n;

  mcusum_in_if  in_ch();
  mcusum_out_if out_ch();
  mcusum_cfg_if cfg_ch();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned alarm_count;

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  mcusum_chart_update #(.DIM(DIM)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  mcusum_chart_checker #(.DIM(DIM)) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .alarm_count  (alarm_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL mcusum_chart_update");
        $finish;
      end
    end
  end

  // Result side: stall in modes of random length
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          2:       out_ch.ready = ($urandom_range(0, 3) == 0);
          3:       out_ch.ready = ((tick % 7) < 4);
          default: out_ch.ready = 1'b0;
        endcase
      end
    end
  end

  // Send one component; gaps open only between bursts
  task automatic send_component(input obs_t value, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9)) inside
        [0:3]:   gap = 0;
        [4:7]:   gap = $urandom_range(1, 4);
        8:       gap = $urandom_range(5, 12);
        default: gap = $urandom_range(20, 40);
      endcase
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.obs_component = value;
    in_ch.is_last       = last;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding vector finish
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_ch.reg_index = idx;
    cfg_ch.wdata     = data;
    cfg_ch.valid     = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic obs_t pick_value(input value_style_t style, input logic neg);
    int mag;
    case (style)
      STYLE_SMALL:  mag = $urandom_range(0, 96);
      STYLE_MEDIUM: mag = $urandom_range(0, 4096);
      STYLE_FULL:   return obs_t'($urandom);
      default:      return neg ? obs_t'(-32768) : obs_t'(32767);
    endcase
    return obs_t'(neg ? -mag : mag);
  endfunction

  // Mostly well-formed vectors; some with is_last scattered at random
  task automatic send_random_vector();
    int unsigned  len;
    int unsigned  pick;
    logic         noisy;
    logic         vec_neg;
    logic         last;
    value_style_t style;
    pick = $urandom_range(0, 99);
    if (pick < 30)      style = STYLE_SMALL;
    else if (pick < 55) style = STYLE_MEDIUM;
    else if (pick < 80) style = STYLE_FULL;
    else                style = STYLE_EXTREME;
    noisy   = ($urandom_range(0, 99) < 15);
    vec_neg = 1'($urandom_range(0, 1));
    len     = noisy ? $urandom_range(1, 12) : $urandom_range(1, DIM);
    for (int i = 0; i < len; i++) begin
      if (noisy)            last = ($urandom_range(0, 3) == 0);
      else if (i < len - 1) last = 1'b0;
      else if (len == DIM)  last = 1'($urandom_range(0, 1));
      else                  last = 1'b1;
      send_component(pick_value(style,
                                (style == STYLE_EXTREME) ? vec_neg
                                                         : 1'($urandom_range(0, 1))),
                     last);
    end
  endtask

  initial begin
    int unsigned phase_start;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.obs_component = '0;
    in_ch.is_last       = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.reg_index    = REG_ALLOWANCE_K;
    cfg_ch.wdata        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero vector: distance not above k, and the DIM-th component ends it without is_last
    repeat (DIM) send_component(obs_t'(0), 1'b0);
    // Short vectors of maximum components; the second one saturates the rescale
    repeat (2) begin
      for (int i = 0; i < 4; i++) send_component(obs_t'(32767), i == 3);
    end
    // Full vector of minimum components closed by is_last
    for (int i = 0; i < DIM; i++) send_component(obs_t'(-32768), i == DIM - 1);
    // Single-component vector
    send_component(obs_t'(1), 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1: begin
            write_reg(REG_ALLOWANCE_K, '0);
            write_reg(REG_CONTROL_LIMIT_H, '0);
          end
          2: begin
            write_reg(REG_ALLOWANCE_K, 32'h0000_FFFF);
            write_reg(REG_CONTROL_LIMIT_H, 32'hFFFF_FFFF);
          end
          3: begin
            write_reg(REG_ALLOWANCE_K, $urandom_range(0, 300));
            write_reg(REG_CONTROL_LIMIT_H, $urandom_range(0, 1 << 22));
          end
          4: begin
            write_reg(REG_ALLOWANCE_K, $urandom_range(1000, 40000));
            write_reg(REG_CONTROL_LIMIT_H, $urandom);
          end
          default: begin
            write_reg(REG_ALLOWANCE_K, $urandom_range(0, 64));
            write_reg(REG_CONTROL_LIMIT_H, H_RESET);
          end
        endcase
      end
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) send_random_vector();
    end

    // Wait out the last results and check that nothing extra shows up
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d components and %0d chart results (%0d with alarm)",
             items_sent, result_count, alarm_count);
    $display("across %0d register settings including both extremes of k and h", NUM_PHASES);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS mcusum_chart_update");
    end else begin
      $display("FAIL mcusum_chart_update");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mcusum_pkg.sv
src/mcusum_in_if.sv
src/mcusum_out_if.sv
src/mcusum_cfg_if.sv
src/mcusum_chart_update.sv
src/mcusum_chk.sv
tb/sv/mcusum_chart_checker.sv
tb/sv/mcusum_chart_update_tb.sv
